>>> hw/rtl/skf_pkg.sv
// ---------------------------------------------------------------------------
// skf_pkg: shared definitions of the scalar Kalman filter
// Word widths, register indexes, reset values and the controller command set.
// ---------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int EST_W     = 32;
  localparam int VAR_W     = 31;
  localparam int GAIN_W    = FRAC_BITS + 1;
  localparam int DEN_W     = VAR_W + 1;
  localparam int DIFF_W    = EST_W + 1;
  localparam int MUL_A_W   = EST_W + 2;
  localparam int MUL_B_W   = GAIN_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 32;
  localparam int DIV_STEPS = GAIN_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ESTIMATE  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VARIANCE  = CFG_IDX_W'(3);

  localparam logic [VAR_W-1:0] RST_PROCESS_NOISE     = VAR_W'(655);
  localparam logic [VAR_W-1:0] RST_MEASUREMENT_NOISE = VAR_W'(65536);
  localparam logic [EST_W-1:0] RST_INITIAL_ESTIMATE  = EST_W'(0);
  localparam logic [VAR_W-1:0] RST_INITIAL_VARIANCE  = VAR_W'(65536);

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic load_in;
    logic pred;
    logic div_step;
    logic div_first;
    logic mul_est;
    logic mul_var;
    logic commit;
    logic cfg_we;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/skf_dpath.sv
// ---------------------------------------------------------------------------
// skf_dpath: filter datapath
// Holds configuration and filter state, runs the restoring gain divider and
// the shared multiplier, and keeps the output word register.
// ---------------------------------------------------------------------------
`default_nettype none

module skf_dpath (
  input  wire                              clk,
  input  wire                              rst,
  input  wire skf_pkg::ctrl_cmd_t          cmd,
  input  wire [skf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [skf_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  wire [skf_pkg::EST_W-1:0]         sample,
  output logic [skf_pkg::EST_W-1:0]        estimate,
  output logic [skf_pkg::GAIN_W-1:0]       gain,
  output logic [skf_pkg::VAR_W-1:0]        variance
);

  logic [skf_pkg::VAR_W-1:0]   process_noise;
  logic [skf_pkg::VAR_W-1:0]   measurement_noise;
  logic [skf_pkg::EST_W-1:0]   initial_estimate;
  logic [skf_pkg::VAR_W-1:0]   initial_variance;
  logic [skf_pkg::EST_W-1:0]   cur_est;
  logic [skf_pkg::VAR_W-1:0]   err_var;

  logic [skf_pkg::EST_W-1:0]   sample_reg;
  logic [skf_pkg::VAR_W-1:0]   p1;
  logic [skf_pkg::DEN_W-1:0]   den;
  logic [skf_pkg::DIFF_W-1:0]  diff;
  logic [skf_pkg::DEN_W-1:0]   rem;
  logic [skf_pkg::GAIN_W-1:0]  quo;
  logic signed [skf_pkg::PROD_W-1:0] prod;
  logic [skf_pkg::EST_W-1:0]   est_res;

  logic [skf_pkg::DEN_W-1:0]   p1_sum;
  logic [skf_pkg::VAR_W-1:0]   p1_c;
  logic [skf_pkg::DEN_W:0]     trial;
  logic                        ge;
  logic [skf_pkg::DEN_W:0]     trial_sub;
  logic signed [skf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [skf_pkg::MUL_B_W-1:0] mul_b;
  logic signed [skf_pkg::PROD_W-1:0]  est_sum;
  logic [skf_pkg::EST_W-1:0]   est_sat;
  logic                        est_ovf;
  logic                        reload;

  // predict: variance grows by Q, saturating at full scale
  always_comb begin
    p1_sum = {1'b0, err_var} + {1'b0, process_noise};
    p1_c   = p1_sum[skf_pkg::DEN_W-1] ? {skf_pkg::VAR_W{1'b1}} : p1_sum[skf_pkg::VAR_W-1:0];
  end

  // one restoring step; a zero denominator never sets a quotient bit
  always_comb begin
    trial     = cmd.div_first ? {2'b00, p1} : {rem, 1'b0};
    ge        = (trial >= {1'b0, den}) && (den != '0);
    trial_sub = trial - {1'b0, den};
  end

  // shared multiplier: d * gain, then p1 * (1 - gain)
  always_comb begin
    if (cmd.mul_var) begin
      mul_a = $signed({3'b000, p1});
      mul_b = $signed({1'b0, skf_pkg::GAIN_ONE - quo});
    end else begin
      mul_a = $signed({diff[skf_pkg::DIFF_W-1], diff});
      mul_b = $signed({1'b0, quo});
    end
  end

  // floor the correction, add, saturate to the estimate range
  always_comb begin
    est_sum = (prod >>> skf_pkg::FRAC_BITS)
            + $signed({{(skf_pkg::PROD_W-skf_pkg::EST_W){cur_est[skf_pkg::EST_W-1]}}, cur_est});
    est_ovf = (est_sum[skf_pkg::PROD_W-1:skf_pkg::EST_W-1] != '0) &&
              (est_sum[skf_pkg::PROD_W-1:skf_pkg::EST_W-1] != '1);
    if (!est_ovf) begin
      est_sat = est_sum[skf_pkg::EST_W-1:0];
    end else if (est_sum[skf_pkg::PROD_W-1]) begin
      est_sat = {1'b1, {(skf_pkg::EST_W-1){1'b0}}};
    end else begin
      est_sat = {1'b0, {(skf_pkg::EST_W-1){1'b1}}};
    end
  end

  assign reload = cmd.cfg_we && (cfg_index <= skf_pkg::REG_INITIAL_VARIANCE);

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= skf_pkg::RST_PROCESS_NOISE;
      measurement_noise <= skf_pkg::RST_MEASUREMENT_NOISE;
      initial_estimate  <= skf_pkg::RST_INITIAL_ESTIMATE;
      initial_variance  <= skf_pkg::RST_INITIAL_VARIANCE;
      cur_est           <= skf_pkg::RST_INITIAL_ESTIMATE;
      err_var           <= skf_pkg::RST_INITIAL_VARIANCE;
    end else if (cmd.cfg_we) begin
      unique case (cfg_index)
        skf_pkg::REG_PROCESS_NOISE:     process_noise     <= cfg_data[skf_pkg::VAR_W-1:0];
        skf_pkg::REG_MEASUREMENT_NOISE: measurement_noise <= cfg_data[skf_pkg::VAR_W-1:0];
        skf_pkg::REG_INITIAL_ESTIMATE:  initial_estimate  <= cfg_data[skf_pkg::EST_W-1:0];
        skf_pkg::REG_INITIAL_VARIANCE:  initial_variance  <= cfg_data[skf_pkg::VAR_W-1:0];
        default: ;
      endcase
      // reload state from the start registers, taking the word just written
      if (reload) begin
        cur_est <= (cfg_index == skf_pkg::REG_INITIAL_ESTIMATE) ?
                   cfg_data[skf_pkg::EST_W-1:0] : initial_estimate;
        err_var <= (cfg_index == skf_pkg::REG_INITIAL_VARIANCE) ?
                   cfg_data[skf_pkg::VAR_W-1:0] : initial_variance;
      end
    end else if (cmd.commit) begin
      cur_est <= est_res;
      err_var <= prod[skf_pkg::FRAC_BITS +: skf_pkg::VAR_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sample_reg <= sample;
    end
    if (cmd.pred) begin
      p1   <= p1_c;
      den  <= {1'b0, p1_c} + {1'b0, measurement_noise};
      diff <= {sample_reg[skf_pkg::EST_W-1], sample_reg} - {cur_est[skf_pkg::EST_W-1], cur_est};
    end
    if (cmd.div_step) begin
      rem <= ge ? trial_sub[skf_pkg::DEN_W-1:0] : trial[skf_pkg::DEN_W-1:0];
      quo <= {quo[skf_pkg::GAIN_W-2:0], ge};
    end
    if (cmd.mul_est || cmd.mul_var) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.mul_var) begin
      est_res <= est_sat;
    end
    if (cmd.commit) begin
      estimate <= est_res;
      gain     <= quo;
      variance <= prod[skf_pkg::FRAC_BITS +: skf_pkg::VAR_W];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/skf_ctrl.sv
// ---------------------------------------------------------------------------
// skf_ctrl: filter sequencer
// Steps one sample through predict, divide, multiply and write-back, and
// owns the handshakes of all three channels.
// ---------------------------------------------------------------------------
`default_nettype none

module skf_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire                  out_stall,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  output skf_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PRED = 6'b000010,
    S_DIV  = 6'b000100,
    S_MULE = 6'b001000,
    S_MULV = 6'b010000,
    S_WB   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic [skf_pkg::DIV_CNT_W-1:0] div_cnt;
  logic                          out_free;

  localparam logic [skf_pkg::DIV_CNT_W-1:0] DIV_LAST = skf_pkg::DIV_CNT_W'(skf_pkg::DIV_STEPS - 1);

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_PRED;
      S_PRED: state_next = S_DIV;
      S_DIV:  if (div_cnt == DIV_LAST) state_next = S_MULE;
      S_MULE: state_next = S_MULV;
      S_MULV: state_next = S_WB;
      S_WB:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.load_in   = (state == S_IDLE) && in_valid;
    cmd.pred      = (state == S_PRED);
    cmd.div_step  = (state == S_DIV);
    cmd.div_first = (state == S_DIV) && (div_cnt == '0);
    cmd.mul_est   = (state == S_MULE);
    cmd.mul_var   = (state == S_MULV);
    cmd.commit    = (state == S_WB) && out_free;
    cmd.cfg_we    = cfg_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        div_cnt <= (div_cnt == DIV_LAST) ? '0 : div_cnt + 1'b1;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_PRED))
    else $error("accepted word did not start predict");

  a_div_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_MULE) |-> ($past(state) == S_DIV && $past(div_cnt) == DIV_LAST))
    else $error("multiply entered before all quotient bits");

  a_out_from_wb: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_WB))
    else $error("output word raised outside write-back");

  a_wb_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB && out_valid && out_stall) |=> (state == S_WB))
    else $error("write-back overran a stalled output word");

endmodule

`default_nettype wire

>>> hw/rtl/scalar_kalman_filter_top.sv
// ---------------------------------------------------------------------------
// scalar_kalman_filter_top: one-dimensional Kalman filter
// Tracks a level estimate and its error variance from one sample per word.
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   -------  ---------  -------------------  ------------------------------
//   in       sink       in_valid / in_stall   sample (signed Q16.16)
//   out      source     out_valid / out_stall estimate, gain, variance
//   cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// After a word is accepted, a predict step, 17 divider steps (one gain bit
// each), two multiplier passes and a write-back put the result word out;
// the input reopens on the edge that registers the result word.
// Reset (rst, synchronous) loads the register reset values and start state.
// A stalled result holds in the output register while the next word runs;
// write-back waits for it. Config writes to a defined register reload the state.
// ---------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter_top (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire [skf_pkg::EST_W-1:0]          sample,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [skf_pkg::EST_W-1:0]         estimate,
  output logic [skf_pkg::GAIN_W-1:0]        gain,
  output logic [skf_pkg::VAR_W-1:0]         variance,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [skf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [skf_pkg::CFG_DAT_W-1:0]      cfg_data
);

  // command bundle from the sequencer to the datapath
  skf_pkg::ctrl_cmd_t cmd;

  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // datapath: configuration, state, divider, multiplier, output word
  skf_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .estimate  (estimate),
    .gain      (gain),
    .variance  (variance)
  );

endmodule

`default_nettype wire

>>> tb/scalar_kalman_filter_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// scalar_kalman_filter_top_tb: self-checking bench of the scalar Kalman filter
// Streams samples through the filter under several noise and start settings,
// predicts every estimate, gain and variance word in the bench itself and
// compares each result word field by field, with random idling on both sides.
// ---------------------------------------------------------------------------

module scalar_kalman_filter_top_tb;

  localparam int  RESET_CYCLES = 11;
  localparam int  HOLDOFF_LEN  = 300;   // long receiver hold-off, fills the block
  localparam int  DONE_WAIT    = 30;    // longer than one word takes through the filter
  localparam int  STALL_LIMIT  = 2000;  // cycles without any handshake

  // Register slots past the last defined one; writes there must be ignored.
  localparam logic [skf_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED =
    skf_pkg::REG_INITIAL_VARIANCE + skf_pkg::CFG_IDX_W'(1);
  localparam logic [skf_pkg::CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;

  localparam longint EST_MAX = 2147483647;
  localparam longint EST_MIN = -longint'(2147483647) - 1;

  typedef struct packed {
    logic [skf_pkg::EST_W-1:0]  estimate;
    logic [skf_pkg::GAIN_W-1:0] gain;
    logic [skf_pkg::VAR_W-1:0]  variance;
  } filter_result_t;

  // -------------------------------------------------------------------------
  // DUT connections; every input starts at a known value
  // -------------------------------------------------------------------------
  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic [skf_pkg::EST_W-1:0]     sample    = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [skf_pkg::EST_W-1:0]     estimate;
  logic [skf_pkg::GAIN_W-1:0]    gain;
  logic [skf_pkg::VAR_W-1:0]     variance;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [skf_pkg::CFG_DAT_W-1:0] cfg_data  = '0;

  scalar_kalman_filter_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .estimate  (estimate),
    .gain      (gain),
    .variance  (variance),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Bench copy of the filter: registers and running state, reset values
  // -------------------------------------------------------------------------
  logic        [skf_pkg::VAR_W-1:0] proc_noise  = skf_pkg::RST_PROCESS_NOISE;
  logic        [skf_pkg::VAR_W-1:0] meas_noise  = skf_pkg::RST_MEASUREMENT_NOISE;
  logic signed [skf_pkg::EST_W-1:0] start_level = skf_pkg::RST_INITIAL_ESTIMATE;
  logic        [skf_pkg::VAR_W-1:0] start_var   = skf_pkg::RST_INITIAL_VARIANCE;
  logic signed [skf_pkg::EST_W-1:0] level_est   = skf_pkg::RST_INITIAL_ESTIMATE;
  logic        [skf_pkg::VAR_W-1:0] level_var   = skf_pkg::RST_INITIAL_VARIANCE;

  filter_result_t pending_results[$];   // predicted words, oldest first
  int             mismatch_count = 0;
  int             quiet_cycles   = 0;
  bit             idling_on      = 1'b1;
  int             holdoff_count  = 0;   // bumped by a test to ask for a hold-off

  // One filter step: grow the variance, form the gain, pull the estimate
  // toward the sample and shrink the variance. Advances the bench state.
  function automatic filter_result_t kalman_update(input logic [skf_pkg::EST_W-1:0] z);
    logic [skf_pkg::VAR_W+1:0]  p1_wide;
    logic [skf_pkg::VAR_W-1:0]  p1;
    longint unsigned            den;
    longint unsigned            num;
    logic [skf_pkg::GAIN_W-1:0] k;
    longint                     diff;
    longint                     corr;
    longint                     next_est;
    longint unsigned            var_prod;
    filter_result_t             res;
    p1_wide = {2'b00, level_var} + {2'b00, proc_noise};
    // saturate the predicted variance
    p1 = (p1_wide > {2'b00, {skf_pkg::VAR_W{1'b1}}}) ? {skf_pkg::VAR_W{1'b1}} :
         p1_wide[skf_pkg::VAR_W-1:0];
    den = longint'(p1) + longint'(meas_noise);
    num = longint'(p1) << skf_pkg::FRAC_BITS;
    // zero denominator gives zero gain
    k = (den == 0) ? '0 : skf_pkg::GAIN_W'(num / den);
    diff = longint'($signed(z)) - longint'(level_est);
    // arithmetic shift floors toward minus infinity
    corr = (diff * longint'(k)) >>> skf_pkg::FRAC_BITS;
    next_est = longint'(level_est) + corr;
    if (next_est > EST_MAX) next_est = EST_MAX;
    if (next_est < EST_MIN) next_est = EST_MIN;
    var_prod = ((longint'(skf_pkg::GAIN_ONE) - longint'(k)) * longint'(p1))
               >> skf_pkg::FRAC_BITS;
    level_est = skf_pkg::EST_W'(next_est);
    level_var = skf_pkg::VAR_W'(var_prod);
    res.estimate = level_est;
    res.gain     = k;
    res.variance = level_var;
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // Shared driver tasks
  // -------------------------------------------------------------------------

  // Offer one sample, hold it until accepted, then queue its prediction.
  // Valid stays high afterwards so back-to-back words need no idle gap between them.
  task automatic send_sample(input logic [skf_pkg::EST_W-1:0] z);
    int gap;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= z;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(kalman_update(z));
  endtask

  // Drop valid and wait until every predicted word has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write one register; valid stays high unless this is the last write.
  task automatic write_reg(input logic [skf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [skf_pkg::CFG_DAT_W-1:0] data, input bit last);
    bit hit;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    hit = 1'b1;
    case (idx)
      skf_pkg::REG_PROCESS_NOISE:     proc_noise  = data[skf_pkg::VAR_W-1:0];
      skf_pkg::REG_MEASUREMENT_NOISE: meas_noise  = data[skf_pkg::VAR_W-1:0];
      skf_pkg::REG_INITIAL_ESTIMATE:  start_level = data[skf_pkg::EST_W-1:0];
      skf_pkg::REG_INITIAL_VARIANCE:  start_var   = data[skf_pkg::VAR_W-1:0];
      default:                        hit = 1'b0;
    endcase
    // any defined register write restarts the filter from its start values
    if (hit) begin
      level_est = start_level;
      level_var = start_var;
    end
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic program_filter(input logic [skf_pkg::CFG_DAT_W-1:0] q,
                                input logic [skf_pkg::CFG_DAT_W-1:0] r,
                                input logic [skf_pkg::CFG_DAT_W-1:0] x0,
                                input logic [skf_pkg::CFG_DAT_W-1:0] p0);
    write_reg(skf_pkg::REG_PROCESS_NOISE,     q,  1'b0);
    write_reg(skf_pkg::REG_MEASUREMENT_NOISE, r,  1'b0);
    write_reg(skf_pkg::REG_INITIAL_ESTIMATE,  x0, 1'b0);
    write_reg(skf_pkg::REG_INITIAL_VARIANCE,  p0, 1'b1);
  endtask

  // Noise and variance picks lean on the extremes; full random words also
  // exercise the masked top bit.
  function automatic logic [skf_pkg::CFG_DAT_W-1:0] pick_variance();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom_range(1, 255);
      3:       return $urandom;
      default: return $urandom_range(0, 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [skf_pkg::EST_W-1:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Receiver: random stall bursts, plus a long hold-off when a test asks
  // -------------------------------------------------------------------------
  int holdoff_seen = 0;
  int hold_left    = 0;
  int burst_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (holdoff_seen != holdoff_count) begin
      holdoff_seen = holdoff_count;
      hold_left    = HOLDOFF_LEN - 1;
      out_stall   <= 1'b1;
    end else if (burst_left != 0) begin
      out_stall <= 1'b1;
      burst_left = burst_left - 1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(1, 4) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // -------------------------------------------------------------------------
  // Result checker: each accepted word against the oldest prediction
  // -------------------------------------------------------------------------
  function automatic void check_field(input string name,
                                      input logic [skf_pkg::EST_W-1:0] want,
                                      input logic [skf_pkg::EST_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    filter_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result word, expected none, actual %h %h %h",
                 $time, estimate, gain, variance);
      end else begin
        want = pending_results.pop_front();
        check_field("estimate", want.estimate, estimate);
        check_field("gain",     skf_pkg::EST_W'(want.gain),     skf_pkg::EST_W'(gain));
        check_field("variance", skf_pkg::EST_W'(want.variance), skf_pkg::EST_W'(variance));
      end
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog: count cycles in which no channel moves a word
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("scalar_kalman_filter_top regression: fail");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Reset values: default noise, zero start, extremes of the sample.
  task automatic test_reset_defaults();
    send_sample('0);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0001);
    wait_for_results();
  endtask

  // No noise and no variance: the denominator is zero, the gain stays zero
  // and the estimate holds.
  task automatic test_zero_denominator();
    program_filter('0, '0, 32'h1234_5678, '0);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    wait_for_results();
  endtask

  // Largest variance plus largest process noise saturates the prediction;
  // first with no measurement noise (gain of one), then with the most.
  task automatic test_variance_overflow();
    program_filter(32'h7FFF_FFFF, '0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'h7FFF_FFFF);
    send_sample('0);
    wait_for_results();
    program_filter(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    wait_for_results();
  endtask

  // Top bits of the 31-bit registers are dropped on write.
  task automatic test_register_masking();
    program_filter(32'hFFFF_FFFF, 32'h8001_0000, 32'hC000_0000, 32'h8000_0000);
    send_sample(32'h4000_0000);
    send_sample(32'hBFFF_FFFF);
    wait_for_results();
  endtask

  // Writes past the last register must neither store nor restart the filter.
  task automatic test_unused_index();
    program_filter(32'd655, 32'd65536, 32'h0001_0000, 32'd131072);
    send_sample(32'h0010_0000);
    send_sample(32'hFFF0_0000);
    wait_for_results();
    write_reg(REG_FIRST_UNUSED, $urandom, 1'b0);
    write_reg(REG_LAST_UNUSED,  $urandom, 1'b1);
    send_sample(32'h0020_0000);
    send_sample(32'h8000_0000);
    wait_for_results();
  endtask

  // Random phases: fresh settings each phase, then samples that mostly
  // scatter around a level with a phase-specific spread, some wild ones.
  task automatic run_random_phase(input int words);
    logic [skf_pkg::EST_W-1:0] level;
    logic [skf_pkg::EST_W-1:0] spread;
    logic [skf_pkg::EST_W-1:0] z;
    int                        width;
    program_filter(pick_variance(), pick_variance(), pick_level(), pick_variance());
    level  = pick_level();
    width  = $urandom_range(4, 31);
    spread = (skf_pkg::EST_W'(1) << width) - 1;
    for (int i = 0; i < words; i++) begin
      case ($urandom_range(0, 15))
        0:       z = pick_level();
        1, 2:    z = $urandom;
        default: z = level + ($urandom & spread) - (spread >> 1);
      endcase
      send_sample(z);
    end
    wait_for_results();
  endtask

  task automatic test_random_sweep();
    for (int ph = 0; ph < 12; ph++) begin
      // every fourth phase runs without idling
      idling_on = (ph % 4 != 3);
      run_random_phase(110);
    end
    idling_on = 1'b1;
  endtask

  // Hold the receiver off for a long stretch while samples keep coming, so
  // the block fills and stalls its input.
  task automatic test_backpressure();
    program_filter(32'd655, 32'd65536, '0, 32'd65536);
    holdoff_count++;
    for (int i = 0; i < 40; i++) send_sample($urandom);
    wait_for_results();
  endtask

  // Closing stretch at full rate with no idling on either side.
  task automatic test_full_rate();
    idling_on = 1'b0;
    run_random_phase(170);
  endtask

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_zero_denominator();
    test_variance_overflow();
    test_register_masking();
    test_unused_index();
    test_random_sweep();
    test_backpressure();
    test_full_rate();

    // let any stray word show up before the verdict
    repeat (DONE_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("scalar_kalman_filter_top regression: pass");
    else
      $display("scalar_kalman_filter_top regression: fail");
    $finish;
  end

endmodule
